// File: hdl/sbfu_pkg.sv
// shared types and constants of the spring force unit
package sbfu_pkg;

  // fraction bits of the fixed point format
  localparam int unsigned FRAC_BITS_DEF = 16;

  // widths fixed by the field formats
  localparam int unsigned COORD_W = 32;
  localparam int unsigned MAG_W   = 33;
  localparam int unsigned SUM_W   = 66;
  localparam int unsigned LEN_W   = 33;
  localparam int unsigned REM_W   = 35;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned EK_W    = 64;

  // spring kinds
  typedef enum logic [1:0] {
    KIND_LINEAR = 2'd0,
    KIND_ABS    = 2'd1,
    KIND_BUNGEE = 2'd2,
    KIND_OFF    = 2'd3
  } sbfu_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KIND  = 2'd0,
    REG_STIFF = 2'd1,
    REG_NAT   = 2'd2,
    REG_NONE  = 2'd3
  } sbfu_reg_e;

  // per item decisions taken once the length is known
  typedef struct packed {
    logic none;
    logic zero;
    logic toward;
  } sbfu_flags_t;

  // difference vector carried alongside the square root
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } sbfu_geom_t;

  // sideband of one divider lane
  typedef struct packed {
    sbfu_flags_t flags;
    logic        neg;
  } sbfu_lane_t;

endpackage

// File: hdl/sbfu_sqrt.sv
// pipelined integer square root, one result bit per stage
module sbfu_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [sbfu_pkg::SUM_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [sbfu_pkg::LEN_W-1:0] root_o,
  output logic [SIDE_W-1:0]         side_o
);
  import sbfu_pkg::*;

  logic [LEN_W:0]                 v_w;
  logic [LEN_W:0][REM_W-1:0]      rem_w;
  logic [LEN_W:0][LEN_W-1:0]      root_w;
  logic [LEN_W:0][SUM_W-1:0]      rad_w;
  logic [LEN_W:0][SIDE_W-1:0]     side_w;

  assign v_w[0]    = valid_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = rad_i;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < LEN_W; k++) begin : g_stage
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;
    logic             v_q;
    logic [REM_W-1:0] rem_q;
    logic [LEN_W-1:0] root_q;
    logic [SUM_W-1:0] rad_q;
    logic [SIDE_W-1:0] side_q;

    // trial subtract of the next radicand pair
    assign cur   = {rem_w[k], rad_w[k][SUM_W-1 -: 2]};
    assign trial = {2'b00, root_w[k], 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_q <= {root_w[k][LEN_W-2:0], ge};
        rad_q  <= {rad_w[k][SUM_W-3:0], 2'b00};
        side_q <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign rad_w[k+1]  = rad_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = v_w[LEN_W];
  assign root_o  = root_w[LEN_W];
  assign side_o  = side_w[LEN_W];

endmodule

// File: hdl/sbfu_div.sv
// pipelined restoring divider, one quotient bit per stage
module sbfu_div #(
  parameter int unsigned QW     = 48,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [sbfu_pkg::LEN_W+QW-1:0]   num_i,
  input  logic [sbfu_pkg::LEN_W-1:0]      den_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [QW-1:0]                   quo_o,
  output logic [SIDE_W-1:0]               side_o
);
  import sbfu_pkg::*;

  logic [QW:0]               v_w;
  logic [QW:0][LEN_W-1:0]    r_w;
  logic [QW:0][QW-1:0]       low_w;
  logic [QW:0][QW-1:0]       q_w;
  logic [QW:0][LEN_W-1:0]    d_w;
  logic [QW:0][SIDE_W-1:0]   side_w;

  // the quotient fits QW bits, so the top part starts below the divisor
  assign v_w[0]    = valid_i;
  assign r_w[0]    = num_i[LEN_W+QW-1:QW];
  assign low_w[0]  = num_i[QW-1:0];
  assign q_w[0]    = '0;
  assign d_w[0]    = den_i;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LEN_W:0]    t;
    logic [LEN_W:0]    diff;
    logic              ge;
    logic              v_q;
    logic [LEN_W-1:0]  r_q;
    logic [QW-1:0]     low_q;
    logic [QW-1:0]     q_q;
    logic [LEN_W-1:0]  d_q;
    logic [SIDE_W-1:0] side_q;

    // shift in the next numerator bit and try the subtract
    assign t    = {r_w[k], low_w[k][QW-1]};
    assign diff = t - {1'b0, d_w[k]};
    assign ge   = (t >= {1'b0, d_w[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q    <= ge ? diff[LEN_W-1:0] : t[LEN_W-1:0];
        low_q  <= {low_w[k][QW-2:0], 1'b0};
        q_q    <= {q_w[k][QW-2:0], ge};
        d_q    <= d_w[k];
        side_q <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign r_w[k+1]    = r_q;
    assign low_w[k+1]  = low_q;
    assign q_w[k+1]    = q_q;
    assign d_w[k+1]    = d_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = v_w[QW];
  assign quo_o   = q_w[QW];
  assign side_o  = side_w[QW];

endmodule

// File: hdl/sbfu_skid.sv
// two entry output buffer that parts the pipeline from the result side
module sbfu_skid #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [W-1:0] in_data_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output logic [W-1:0] out_data_o,
  input  logic         out_ready_i
);

  logic         out_v_q, spare_v_q;
  logic [W-1:0] out_q, spare_q;
  logic         in_fire;

  assign in_ready_o = !spare_v_q;
  assign in_fire    = in_valid_i && !spare_v_q;

  // valid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q   <= spare_v_q || in_fire;
      spare_v_q <= 1'b0;
    end else if (in_fire) begin
      spare_v_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= spare_v_q ? spare_q : in_data_i;
    end else if (in_fire) begin
      spare_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/spring_bungee_force_unit_core.sv
// spring force unit: difference, length, magnitude, per axis divide, saturation
// throughput: one request per cycle; set by the 33 stage square root and the
// 64 - FRAC_BITS stage dividers, all fully pipelined
// the whole pipeline holds while the two entry output buffer is full
// reset clears all valid bits and loads kind linear, stiffness 65536 (1.0 at FRAC_BITS 16), rest length 0
module spring_bungee_force_unit_core #(
  parameter int unsigned FRAC_BITS = sbfu_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pos_x, pos_y, pos_z, ref_x, ref_y, ref_z from bit 0 up
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // force_x, force_y, force_z from bit 0 up
  output logic [95:0]  m_axis_tdata,
  // applied, clipped from bit 0 up
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import sbfu_pkg::*;

  localparam int unsigned MW     = EK_W - FRAC_BITS;
  localparam int unsigned ML     = MW / 2;
  localparam int unsigned MH     = MW - ML;
  localparam int unsigned NUM_W  = LEN_W + MW;
  localparam int unsigned GEOM_W = $bits(sbfu_geom_t);
  localparam int unsigned LANE_W = $bits(sbfu_lane_t);
  localparam int unsigned RES_W  = 3 * COORD_W + 2;

  logic en;

  // configuration registers
  sbfu_kind_e       kind_q;
  logic [CFG_W-1:0] stiff_q, nat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_LINEAR;
      stiff_q <= CFG_W'(65536);
      nat_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (sbfu_reg_e'(cfg_index_i))
        REG_KIND:  kind_q  <= sbfu_kind_e'(cfg_data_i[1:0]);
        REG_STIFF: stiff_q <= cfg_data_i[CFG_W-1:0];
        REG_NAT:   nat_q   <= cfg_data_i[CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  // stage 1: differences
  logic       v1_q;
  sbfu_geom_t g1_q;
  sbfu_geom_t g1_d;

  always_comb begin
    logic signed [COORD_W:0] d;
    for (int i = 0; i < 3; i++) begin
      d = $signed({s_axis_tdata[COORD_W*i + COORD_W-1], s_axis_tdata[COORD_W*i +: COORD_W]})
        - $signed({s_axis_tdata[COORD_W*(i+3) + COORD_W-1],
                   s_axis_tdata[COORD_W*(i+3) +: COORD_W]});
      g1_d.neg[i] = d[COORD_W];
      g1_d.mag[i] = d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) g1_q <= g1_d;
  end

  // stage 2: squares
  logic                  v2_q;
  sbfu_geom_t            g2_q;
  logic [2:0][SUM_W-1:0] sq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_q <= g1_q;
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= {{(SUM_W-MAG_W){1'b0}}, g1_q.mag[i]}
                  * {{(SUM_W-MAG_W){1'b0}}, g1_q.mag[i]};
      end
    end
  end

  // stage 3: sum of squares
  logic             v3_q;
  sbfu_geom_t       g3_q;
  logic [SUM_W-1:0] sum3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g3_q   <= g2_q;
      sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    end
  end

  // length
  logic              vs;
  logic [LEN_W-1:0]  len_s;
  logic [GEOM_W-1:0] gs_raw;
  sbfu_geom_t        gs;

  sbfu_sqrt #(.SIDE_W(GEOM_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  (g3_q),
    .valid_o (vs),
    .root_o  (len_s),
    .side_o  (gs_raw)
  );
  assign gs = sbfu_geom_t'(gs_raw);

  // stage 4: spring extension and decisions
  logic             v4_q;
  sbfu_geom_t       g4_q;
  sbfu_flags_t      f4_q, f4_d;
  logic [LEN_W-1:0] len4_q, e4_q, e4_d;
  logic             nat_ge;

  assign nat_ge = ({{(LEN_W-CFG_W){1'b0}}, nat_q} >= len_s);

  // a bungee is slack while shorter than its rest length
  always_comb begin
    e4_d = nat_ge ? ({{(LEN_W-CFG_W){1'b0}}, nat_q} - len_s)
                  : (len_s - {{(LEN_W-CFG_W){1'b0}}, nat_q});
    f4_d.none   = (kind_q == KIND_OFF)
                || ((kind_q == KIND_BUNGEE) && nat_ge && (len_s != {{(LEN_W-CFG_W){1'b0}}, nat_q}));
    f4_d.zero   = (len_s == '0);
    f4_d.toward = !((kind_q == KIND_LINEAR) && nat_ge);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= vs;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g4_q   <= gs;
      f4_q   <= f4_d;
      len4_q <= len_s;
      e4_q   <= e4_d;
    end
  end

  // stage 5: extension times stiffness
  logic            v5_q;
  sbfu_geom_t      g5_q;
  sbfu_flags_t     f5_q;
  logic [LEN_W-1:0] len5_q;
  logic [EK_W-1:0] ek5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g5_q   <= g4_q;
      f5_q   <= f4_q;
      len5_q <= len4_q;
      ek5_q  <= {{(EK_W-LEN_W){1'b0}}, e4_q} * {{(EK_W-CFG_W){1'b0}}, stiff_q};
    end
  end

  // stage 6: axis magnitude times force, as two partial products
  logic                          v6_q;
  sbfu_geom_t                    g6_q;
  sbfu_flags_t                   f6_q;
  logic [LEN_W-1:0]              len6_q;
  logic [2:0][MAG_W+ML-1:0]      plo6_q;
  logic [2:0][MAG_W+MH-1:0]      phi6_q;
  logic [MW-1:0]                 m5;

  assign m5 = ek5_q[EK_W-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g6_q   <= g5_q;
      f6_q   <= f5_q;
      len6_q <= len5_q;
      for (int i = 0; i < 3; i++) begin
        plo6_q[i] <= {{ML{1'b0}}, g5_q.mag[i]} * {{MAG_W{1'b0}}, m5[ML-1:0]};
        phi6_q[i] <= {{MH{1'b0}}, g5_q.mag[i]} * {{MAG_W{1'b0}}, m5[MW-1:ML]};
      end
    end
  end

  // stage 7: combine partial products into the dividend
  logic                  v7_q;
  sbfu_lane_t [2:0]      side7_q;
  logic [LEN_W-1:0]      len7_q;
  logic [2:0][NUM_W-1:0] num7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len7_q <= len6_q;
      for (int i = 0; i < 3; i++) begin
        side7_q[i].flags <= f6_q;
        side7_q[i].neg   <= g6_q.neg[i];
        num7_q[i] <= {{(NUM_W-MAG_W-ML){1'b0}}, plo6_q[i]}
                   + {phi6_q[i], {ML{1'b0}}};
      end
    end
  end

  // per axis division by the length
  logic [2:0]              vd;
  logic [2:0][MW-1:0]      quo;
  logic [2:0][LANE_W-1:0]  lane_raw;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sbfu_div #(.QW(MW), .SIDE_W(LANE_W)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v7_q),
      .num_i   (num7_q[i]),
      .den_i   (len7_q),
      .side_i  (side7_q[i]),
      .valid_o (vd[i]),
      .quo_o   (quo[i]),
      .side_o  (lane_raw[i])
    );
  end

  // sign, saturation and flags
  logic [RES_W-1:0] res;

  always_comb begin
    sbfu_lane_t  ln;
    sbfu_flags_t fl;
    logic        n;
    logic        clip;
    logic [COORD_W-1:0] f;
    ln   = sbfu_lane_t'(lane_raw[0]);
    fl   = ln.flags;
    clip = 1'b0;
    res  = '0;
    for (int i = 0; i < 3; i++) begin
      ln = sbfu_lane_t'(lane_raw[i]);
      n  = (fl.toward ? !ln.neg : ln.neg) && (quo[i] != '0);
      if (n) begin
        if (quo[i] > MW'(33'h0_8000_0000)) begin
          f    = 32'h8000_0000;
          clip = 1'b1;
        end else begin
          f = COORD_W'(MW'(0) - quo[i]);
        end
      end else if (quo[i] > MW'(33'h0_7fff_ffff)) begin
        f    = 32'h7fff_ffff;
        clip = 1'b1;
      end else begin
        f = quo[i][COORD_W-1:0];
      end
      if (!fl.none && !fl.zero) res[COORD_W*i +: COORD_W] = f;
    end
    res[3*COORD_W]     = !fl.none;
    res[3*COORD_W + 1] = clip && !fl.none && !fl.zero;
  end

  // output buffer
  logic [RES_W-1:0] out_data;

  sbfu_skid #(.W(RES_W)) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vd[0]),
    .in_data_i   (res),
    .in_ready_o  (en),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = out_data[3*COORD_W-1:0];
  assign m_axis_tuser  = out_data[RES_W-1:3*COORD_W];

endmodule

// File: hdl/sbfu_checker.sv
// port level checks of the spring force unit and their binding
module sbfu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // a waiting result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // a waiting result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // saturation only where a force is applied
  a_clip_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("clipped without applied force");

  // no force carries all zero components
  a_slack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("force on a slack spring");

endmodule

bind spring_bungee_force_unit_core sbfu_checker u_sbfu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// File: tb/tb_top.sv
// self-checking testbench of the spring force unit core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbfu_pkg::*;

  localparam int unsigned FRAC     = 16;
  localparam int unsigned LATENCY  = 89;
  localparam int          N_RANDOM = 1100;
  localparam int          N_PHASES = 10;
  localparam longint      LIMIT    = 400000;

  typedef struct packed {
    logic [31:0] rz, ry, rx, pz, py, px;
  } pair_t;

  typedef struct packed {
    logic        clipped;
    logic        applied;
    logic [31:0] fz, fy, fx;
  } force_t;

  typedef struct packed {
    logic        is_cfg;
    sbfu_reg_e   idx;
    logic [31:0] data;
    pair_t       pair;
  } req_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  spring_bungee_force_unit_core #(.FRAC_BITS(FRAC)) dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // predictor configuration, tracked as writes are accepted
  sbfu_kind_e  kind_q = KIND_LINEAR;
  logic [30:0] stiff_q = 31'd65536;
  logic [30:0] rest_q = '0;

  req_t   pending_q[$];
  force_t expected_forces[$];
  int     n_errors = 0;
  longint cycle_cnt = 0;
  bit     stim_done = 1'b0;
  int     hold_cycles = 0;
  bit     hold_done = 1'b0;
  int     n_pairs = 0;
  int     n_sent = 0;
  int     hold_at = 32'h7fff_ffff;

  // integer square root of a sum of squares
  function automatic logic [35:0] isqrt(logic [67:0] n);
    logic [35:0] r;
    logic [35:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (36'd1 << b);
      if ({36'd0, c} * {36'd0, c} <= {4'd0, n}) r = c;
    end
    return r;
  endfunction

  // spring force on the particle for the current settings
  function automatic force_t spring_force(pair_t p);
    force_t      f;
    logic [32:0] mag[3];
    logic        neg[3];
    logic [67:0] sum;
    logic [35:0] len;
    logic [63:0] e, m, c;
    logic [127:0] prod;
    logic        toward, n;
    logic signed [33:0] d;
    logic [31:0] pv[3], rv[3], out[3];
    pv = '{p.px, p.py, p.pz};
    rv = '{p.rx, p.ry, p.rz};
    f = '0;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({{2{pv[i][31]}}, pv[i]}) - $signed({{2{rv[i][31]}}, rv[i]});
      neg[i] = d < 0;
      mag[i] = neg[i] ? 33'(-d) : 33'(d);
      sum += {35'd0, mag[i]} * {35'd0, mag[i]};
    end
    len = isqrt(sum);
    f.applied = 1'b1;
    if (kind_q == KIND_OFF || (kind_q == KIND_BUNGEE && len < {5'd0, rest_q})) begin
      f.applied = 1'b0;
      return f;
    end
    if (len == 0) return f;
    e = ({5'd0, rest_q} >= len) ? 64'(rest_q) - 64'(len) : 64'(len) - 64'(rest_q);
    prod = {64'd0, e} * {97'd0, stiff_q};
    m = prod[FRAC +: 64];
    toward = !(kind_q == KIND_LINEAR && {5'd0, rest_q} >= len);
    for (int i = 0; i < 3; i++) begin
      prod = ({95'd0, mag[i]} * {64'd0, m}) / {92'd0, len};
      c = prod[63:0];
      n = toward ? !neg[i] : neg[i];
      if (prod == 0) n = 1'b0;
      if (n) begin
        if (prod > 128'h8000_0000) begin c = 64'h8000_0000; f.clipped = 1'b1; end
        out[i] = 32'(-c);
      end else begin
        if (prod > 128'h7fff_ffff) begin c = 64'h7fff_ffff; f.clipped = 1'b1; end
        out[i] = c[31:0];
      end
    end
    f.fx = out[0];
    f.fy = out[1];
    f.fz = out[2];
    return f;
  endfunction

  // a random coordinate, biased to extremes and small values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
    p.rx = rand_coord(); p.ry = rand_coord(); p.rz = rand_coord();
    if ($urandom_range(0, 9) == 0) p.rx = p.px;
    if ($urandom_range(0, 9) == 0) {p.ry, p.rz} = {p.py, p.pz};
    return p;
  endfunction

  task automatic add_pair(pair_t p);
    req_t r;
    r = '0;
    r.pair = p;
    pending_q = {pending_q, r};
    n_pairs++;
  endtask

  task automatic add_cfg(sbfu_reg_e idx, logic [31:0] v);
    req_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = v;
    pending_q = {pending_q, r};
  endtask

  // fill the request queue: directed then random phases
  initial begin
    pair_t p;
    logic [31:0] kinds[4];
    kinds = '{KIND_LINEAR, KIND_ABS, KIND_BUNGEE, KIND_OFF};
    // directed: zero length, extremes, small vectors
    add_pair('0);
    p = '0; p.px = 32'h7fff_ffff; p.rx = 32'h8000_0000; add_pair(p);
    p = '0; p.py = 32'h8000_0000; p.ry = 32'h7fff_ffff; add_pair(p);
    p = {6{32'h7fff_ffff}}; add_pair(p);
    p = '0; p.pz = 32'h0003_0000; add_pair(p);
    p = '0; p.px = 32'hffff_0000; p.py = 32'h0001_0000; add_pair(p);
    add_cfg(REG_NAT, 32'h0002_0000);
    p = '0; p.px = 32'h0001_0000; add_pair(p);
    p = '0; p.px = 32'h0005_0000; add_pair(p);
    for (int k = 1; k < 4; k++) begin
      add_cfg(REG_KIND, kinds[k] | 32'hffff_fffc);
      p = '0; p.px = 32'h0001_0000; add_pair(p);
      p = '0; p.px = 32'hfffb_0000; add_pair(p);
      add_pair('0);
    end
    add_cfg(REG_STIFF, 32'hffff_ffff);
    add_cfg(REG_NAT, 32'hffff_ffff);
    add_cfg(REG_KIND, KIND_ABS);
    p = '0; p.px = 32'h7fff_ffff; p.rx = 32'h8000_0000; add_pair(p);
    add_cfg(REG_NONE, 32'h1234_5678);
    add_pair(rand_pair());
    // random phases with changing settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      add_cfg(REG_KIND, $urandom_range(0, 15) == 0 ? KIND_OFF : kinds[$urandom_range(0, 2)]);
      case ($urandom_range(0, 3))
        0: add_cfg(REG_STIFF, $urandom());
        1: add_cfg(REG_STIFF, 0);
        default: add_cfg(REG_STIFF, $urandom_range(0, 4 << 16));
      endcase
      case ($urandom_range(0, 3))
        0: add_cfg(REG_NAT, $urandom());
        1: add_cfg(REG_NAT, 0);
        default: add_cfg(REG_NAT, $urandom_range(0, 150 << 16));
      endcase
      // the long receiver hold-off starts with the first long run of requests
      if (ph == 0) hold_at = n_pairs;
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) add_pair(rand_pair());
    end
  end

  // driver: bursts and gaps, config written only when the pipeline is empty
  int  burst_left = 0;
  int  gap_left = 0;
  int  drain_wait = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_forces = {expected_forces, spring_force(s_axis_tdata)};
        n_sent <= n_sent + 1;
        void'(pending_q.pop_front());
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (sbfu_reg_e'(cfg_index_i))
          REG_KIND:  kind_q <= sbfu_kind_e'(cfg_data_i[1:0]);
          REG_STIFF: stiff_q <= cfg_data_i[30:0];
          REG_NAT:   rest_q <= cfg_data_i[30:0];
          default: ;
        endcase
        void'(pending_q.pop_front());
      end
      if ((s_axis_tvalid && !s_axis_tready) || (cfg_valid_i && !cfg_ready_o)) begin
        // hold the offered request
      end else if (pending_q.size() > 0) begin
        req_t nxt;
        logic send_pair;
        logic send_cfg;
        nxt = pending_q[0];
        send_pair = 1'b0;
        send_cfg = 1'b0;
        if (nxt.is_cfg) begin
          if (expected_forces.size() == 0 && !(s_axis_tvalid && s_axis_tready)) begin
            if (drain_wait < LATENCY + 4) drain_wait <= drain_wait + 1;
            else begin
              drain_wait <= 0;
              send_cfg = 1'b1;
              cfg_index_i <= nxt.idx;
              cfg_data_i <= nxt.data;
            end
          end else drain_wait <= 0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          send_pair = 1'b1;
          s_axis_tdata <= nxt.pair;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
        s_axis_tvalid <= send_pair;
        cfg_valid_i <= send_cfg;
      end else begin
        s_axis_tvalid <= 1'b0;
        cfg_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver stall pattern, with one long hold-off while requests keep coming
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_sent > hold_at) begin
        hold_cycles <= 600;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
        if (hold_cycles > 1) m_axis_tready <= 1'b0;
        else if (cycle_cnt[9:8] == 2'b01) m_axis_tready <= 1'b1;
        else m_axis_tready <= $urandom_range(0, 3) != 0;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    force_t exp_f;
    force_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata};
      if (expected_forces.size() == 0) begin
        $error("unexpected result %h", got);
        n_errors++;
      end else begin
        exp_f = expected_forces.pop_front();
        if (got.fx != exp_f.fx) begin
          $error("force_x expected %h got %h", exp_f.fx, got.fx); n_errors++;
        end
        if (got.fy != exp_f.fy) begin
          $error("force_y expected %h got %h", exp_f.fy, got.fy); n_errors++;
        end
        if (got.fz != exp_f.fz) begin
          $error("force_z expected %h got %h", exp_f.fz, got.fz); n_errors++;
        end
        if (got.applied != exp_f.applied) begin
          $error("applied expected %b got %b", exp_f.applied, got.applied); n_errors++;
        end
        if (got.clipped != exp_f.clipped) begin
          $error("clipped expected %b got %b", exp_f.clipped, got.clipped); n_errors++;
        end
      end
    end
  end

  // reset, end of run and timeout
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stim_done && expected_forces.size() == 0);
        repeat (LATENCY + 20) @(posedge clk_i);
        if (n_errors == 0 && expected_forces.size() == 0)
          $display("Testbench completed without errors");
        else
          $display("Testbench completed WITH ERRORS");
      end
      begin
        wait (cycle_cnt >= LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Testbench completed WITH ERRORS");
      end
    join_any
    $finish;
  end

endmodule
